[src/assert_macros.svh]
// Assertion macros used by the checker file of this project.
// Each macro takes a label, a clock, an active-low reset, the two sides of
// the implication and the text reported on a failure.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/kcef_pkg.sv]
// ============================================================================
// kcef_pkg
// Types and constants of the key-change event FIFO: beat structs, item
// kind codes, pop status codes, queued operation types and the back-end state type.
// ============================================================================
package kcef_pkg;

  // Ring of FifoDepth slots, holding at most FifoDepth-1 events.
  localparam int unsigned FifoDepth = 1024;
  localparam int unsigned IdxW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = 10;

  // All 32 key bits of a pattern count.
  localparam logic [31:0] KeyMask = 32'hFFFF_FFFF;

  // Item kind codes.
  localparam logic [1:0] KindTick = 2'd0;
  localparam logic [1:0] KindCtrl = 2'd1;
  localparam logic [1:0] KindPop  = 2'd2;

  // Pop status codes.
  localparam logic [2:0] StNone      = 3'd0;
  localparam logic [2:0] StEvent     = 3'd1;
  localparam logic [2:0] StEmptyRun  = 3'd2;
  localparam logic [2:0] StEmptyStop = 3'd3;
  localparam logic [2:0] StOverflow  = 3'd4;

  // Input beat.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] key_pattern;
    logic [31:0] sample_count;
    logic [31:0] timestamp;
    logic        flush_buffer;
    logic        clear_errors;
    logic        stop_capture;
    logic        start_capture;
  } kcef_in_t;

  // Output beat.
  typedef struct packed {
    logic [2:0]      read_status;
    logic [31:0]     event_pattern;
    logic [31:0]     event_count;
    logic [31:0]     event_time;
    logic            running_flag;
    logic            overflow_flag;
    logic [CntW-1:0] entries_count;
  } kcef_out_t;

  // Operation classes handed from the front end to the back end.
  typedef enum logic [1:0] {
    OP_TICK,
    OP_CTRL,
    OP_POP,
    OP_NOP
  } kcef_op_e;

  // One queued operation.
  typedef struct packed {
    kcef_op_e    op;
    logic [31:0] key;
    logic [31:0] count;
    logic [31:0] stamp;
    logic        flush;
    logic        clr_err;
    logic        stop;
    logic        start;
  } kcef_op_t;

  // Back-end states.
  typedef enum logic {
    BK_EXEC,
    BK_POP
  } kcef_bk_state_e;

endpackage

[src/key_change_event_fifo_top.sv]
// ============================================================================
// key_change_event_fifo_top
// Key-change event recorder with a ring FIFO of captured key events.
// ============================================================================
// Usage:
// The input channel (in_valid_i, in_stall_o, in_data_i) takes one beat per
// item: a scan tick, a control write or a pop. The output channel
// (out_valid_o, out_stall_i, out_data_o) returns exactly one beat per item,
// in order. A beat moves at a clock edge with valid high and stall low.
// Accepted items enter a two-entry queue; the back end then executes them.
// A tick, control or non-event pop result is loaded into the output
// register when the back end executes the item; a pop that returns an
// event first waits in the BK_POP state for the registered read of the
// event memory. The back end takes no new item while in BK_POP, and none
// while the output is stalled.
// Reset clears the ring indexes, the previous pattern and the overflow
// flag, and starts with capture running. The event memory is not cleared.
// While the receiver stalls, the output beat holds; the queue fills and
// in_stall_o rises once two items wait.
module key_change_event_fifo_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  kcef_pkg::kcef_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output kcef_pkg::kcef_out_t out_data_o
);

  logic               op_valid;
  logic               op_take;
  kcef_pkg::kcef_op_t op;

  // Front end: classify and queue.
  kcef_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .op_valid_o (op_valid),
    .op_o       (op),
    .op_take_i  (op_take)
  );

  // Back end: execute against the event ring.
  kcef_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (op_valid),
    .op_i        (op),
    .op_take_o   (op_take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[src/kcef_front.sv]
// ============================================================================
// kcef_front
// Accepts input beats, classifies them by kind and queues the resulting
// operations in a two-entry queue for the back end.
// ============================================================================
module kcef_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  kcef_pkg::kcef_in_t in_data_i,
  output logic              op_valid_o,
  output kcef_pkg::kcef_op_t op_o,
  input  logic              op_take_i
);

  kcef_pkg::kcef_op_t op_new;
  kcef_pkg::kcef_op_t q_mem_q [2];
  logic               wr_ptr_q, wr_ptr_d;
  logic               rd_ptr_q, rd_ptr_d;
  logic [1:0]         cnt_q, cnt_d;
  logic               push, pop;

  // Classify the incoming beat by kind; every field is kept whatever the kind.
  always_comb begin
    op_new         = '0;
    op_new.op      = kcef_pkg::OP_NOP;
    op_new.key     = in_data_i.key_pattern & kcef_pkg::KeyMask;
    op_new.count   = in_data_i.sample_count;
    op_new.stamp   = in_data_i.timestamp;
    op_new.flush   = in_data_i.flush_buffer;
    op_new.clr_err = in_data_i.clear_errors;
    op_new.stop    = in_data_i.stop_capture;
    op_new.start   = in_data_i.start_capture;
    case (in_data_i.kind)
      kcef_pkg::KindTick: op_new.op = kcef_pkg::OP_TICK;
      kcef_pkg::KindCtrl: op_new.op = kcef_pkg::OP_CTRL;
      kcef_pkg::KindPop:  op_new.op = kcef_pkg::OP_POP;
      default:            op_new.op = kcef_pkg::OP_NOP;
    endcase
  end

  // Queue control.
  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = op_take_i && (cnt_q != 2'd0);
  assign op_valid_o = (cnt_q != 2'd0);
  assign op_o       = q_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue payload storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= op_new;
    end
  end

endmodule

[src/kcef_back.sv]
// ============================================================================
// kcef_back
// Executes queued operations against the event ring: change detection and
// push on ticks, control updates, and pops through a registered-read memory.
// ============================================================================
module kcef_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               op_valid_i,
  input  kcef_pkg::kcef_op_t op_i,
  output logic               op_take_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output kcef_pkg::kcef_out_t out_data_o
);

  typedef struct packed {
    logic [31:0] stamp;
    logic [31:0] count;
    logic [31:0] key;
  } slot_t;

  slot_t mem_q [kcef_pkg::FifoDepth];
  slot_t rd_data_q;

  kcef_pkg::kcef_bk_state_e state_q, state_d;
  logic [kcef_pkg::IdxW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [kcef_pkg::IdxW-1:0] held, held_after;
  logic [31:0]               prev_q, prev_d;
  logic                      seen_q, seen_d;
  logic                      run_q, run_d;
  logic                      ovf_q, ovf_d;
  logic                      out_valid_q;
  kcef_pkg::kcef_out_t       out_q, out_d;
  logic                      out_free, out_load, mem_we;

  assign out_free = !out_valid_q || !out_stall_i;
  assign held     = wr_q - rd_q;

  // Execute one operation when the output register can take its result.
  always_comb begin
    state_d   = state_q;
    wr_d      = wr_q;
    rd_d      = rd_q;
    prev_d    = prev_q;
    seen_d    = seen_q;
    run_d     = run_q;
    ovf_d     = ovf_q;
    op_take_o = 1'b0;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    out_d     = '0;
    out_d.read_status = kcef_pkg::StNone;
    case (state_q)
      kcef_pkg::BK_EXEC: begin
        if (op_valid_i && out_free) begin
          op_take_o = 1'b1;
          out_load  = 1'b1;
          case (op_i.op)
            kcef_pkg::OP_TICK: begin
              if (seen_q && run_q && (op_i.key != prev_q)) begin
                if (held == kcef_pkg::IdxW'(kcef_pkg::FifoDepth - 1)) begin
                  ovf_d = 1'b1;
                end else begin
                  mem_we = 1'b1;
                  wr_d   = wr_q + 1'b1;
                end
              end
              seen_d = 1'b1;
              prev_d = op_i.key;
            end
            kcef_pkg::OP_CTRL: begin
              if (op_i.flush) begin
                wr_d = '0;
                rd_d = '0;
              end
              if (op_i.clr_err) begin
                ovf_d = 1'b0;
              end
              if (op_i.stop) begin
                run_d = 1'b0;
              end else if (op_i.start) begin
                run_d = 1'b1;
              end
            end
            kcef_pkg::OP_POP: begin
              if (held == '0) begin
                out_d.read_status = run_q ? kcef_pkg::StEmptyRun : kcef_pkg::StEmptyStop;
              end else if (ovf_q) begin
                out_d.read_status = kcef_pkg::StOverflow;
              end else begin
                // The slot read is in flight; the result goes out from BK_POP once the output register is free.
                out_load = 1'b0;
                state_d  = kcef_pkg::BK_POP;
              end
            end
            default: begin
              out_d.read_status = kcef_pkg::StNone;
            end
          endcase
        end
      end
      kcef_pkg::BK_POP: begin
        if (out_free) begin
          out_load            = 1'b1;
          rd_d                = rd_q + 1'b1;
          out_d.read_status   = kcef_pkg::StEvent;
          out_d.event_pattern = rd_data_q.key;
          out_d.event_count   = rd_data_q.count;
          out_d.event_time    = rd_data_q.stamp;
          state_d             = kcef_pkg::BK_EXEC;
        end
      end
      default: begin
        state_d = kcef_pkg::BK_EXEC;
      end
    endcase
    held_after          = wr_d - rd_d;
    out_d.running_flag  = run_d;
    out_d.overflow_flag = ovf_d;
    out_d.entries_count = kcef_pkg::CntW'(held_after);
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kcef_pkg::BK_EXEC;
      wr_q        <= '0;
      rd_q        <= '0;
      prev_q      <= '0;
      seen_q      <= 1'b0;
      run_q       <= 1'b1;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      prev_q  <= prev_d;
      seen_q  <= seen_d;
      run_q   <= run_d;
      ovf_q   <= ovf_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  // Event ring memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_q] <= '{stamp: op_i.stamp, count: op_i.count, key: op_i.key};
    end
    rd_data_q <= mem_q[rd_q];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[src/kcef_checker.sv]
// ============================================================================
// kcef_port_checker
// Port-level checks of the key-change event FIFO, bound to the top level.
// ============================================================================
`include "assert_macros.svh"

module kcef_port_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input kcef_pkg::kcef_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input kcef_pkg::kcef_out_t out_data_o
);

  logic out_held, in_held, no_event, empty_run, empty_stop, ovf_err;
  logic fields_zero, empty_ok, ovf_ok;

  assign out_held   = out_valid_o && out_stall_i;
  assign in_held    = in_valid_i && in_stall_o;
  assign no_event   = out_valid_o && (out_data_o.read_status != kcef_pkg::StEvent);
  assign empty_run  = out_valid_o && (out_data_o.read_status == kcef_pkg::StEmptyRun);
  assign empty_stop = out_valid_o && (out_data_o.read_status == kcef_pkg::StEmptyStop);
  assign ovf_err    = out_valid_o && (out_data_o.read_status == kcef_pkg::StOverflow);

  assign fields_zero = (out_data_o.event_pattern == '0) && (out_data_o.event_count == '0) &&
                       (out_data_o.event_time == '0);
  assign empty_ok    = (out_data_o.entries_count == '0) &&
                       (out_data_o.running_flag == empty_run);
  assign ovf_ok      = out_data_o.overflow_flag && (out_data_o.entries_count != '0);

  // A stalled output beat stays and does not change.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(out_data_o), "output beat changed while stalled")

  // A stalled input beat stays and does not change.
  `ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_held, in_valid_i && $stable(in_data_i), "input beat changed while stalled")

  // Only a beat that delivers an event carries event fields.
  `ASSERT_IMPLY(a_zero_fields, clk_i, rst_ni, no_event, fields_zero, "event fields set without an event")

  // An empty report matches the running flag and an empty ring.
  `ASSERT_IMPLY(a_empty_run, clk_i, rst_ni, empty_run || empty_stop, empty_ok, "empty status disagrees with flags")

  // An overflow report needs the sticky flag and a non-empty ring.
  `ASSERT_IMPLY(a_ovf_err, clk_i, rst_ni, ovf_err, ovf_ok, "overflow status without overflow state")

endmodule

bind key_change_event_fifo_top kcef_port_checker u_kcef_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
